// ===== sv/bfe_pkg.sv =====
// Shared types and constants for the bit field expander.
package bfe_pkg;

    localparam logic [4:0] FIELD_MIN = 5'd8;
    localparam logic [4:0] FIELD_MAX = 5'd25;
    localparam logic [4:0] FIELD_RST = 5'd21;
    localparam logic [1:0] PAD_RST   = 2'd0;

    localparam logic CFG_FIELD_BITS = 1'b0;
    localparam logic CFG_PAD_BYTES  = 1'b1;

    typedef struct packed {
        logic [24:0] field;
        logic [1:0]  nb_m1;
        logic [1:0]  pad;
    } t_field_ent;

endpackage

// ===== sv/bfe_front.sv =====
// Front end: config registers, bit accumulator and field extraction.
module bfe_front import bfe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [4:0] i_cfg_data,
    input  logic       i_accept,
    input  logic [7:0] i_in_byte,
    input  logic       i_start_of_array,
    output logic       o_push,
    output t_field_ent o_ent
);

    logic [4:0]  r_field_bits, n_field_bits;
    logic [1:0]  r_pad_bytes, n_pad_bytes;
    logic [31:0] r_acc, n_acc;
    logic [4:0]  r_held, n_held;

    logic [4:0]  width;
    logic [4:0]  width_m1;
    logic [31:0] acc_base;
    logic [4:0]  held_base;
    logic [5:0]  count;
    logic [5:0]  rem;
    logic        emit;
    logic [31:0] shifted;
    logic [31:0] mask;

    always_comb begin
        width = r_field_bits;
        if (width < FIELD_MIN) begin
            width = FIELD_MIN;
        end else if (width > FIELD_MAX) begin
            width = FIELD_MAX;
        end
        width_m1  = width - 5'd1;
        acc_base  = i_start_of_array ? 32'd0 : r_acc;
        held_base = i_start_of_array ? 5'd0 : r_held;
        n_acc     = {acc_base[23:0], i_in_byte};
        count     = {1'b0, held_base} + 6'd8;
        emit      = count >= {1'b0, width};
        rem       = count - {1'b0, width};
        n_held    = emit ? rem[4:0] : count[4:0];
        shifted   = n_acc >> rem[4:0];
        mask      = ~(32'hFFFF_FFFF << width);

        o_push       = i_accept && emit;
        o_ent.field  = shifted[24:0] & mask[24:0];
        o_ent.nb_m1  = width_m1[4:3];
        o_ent.pad    = r_pad_bytes;

        n_field_bits = r_field_bits;
        n_pad_bytes  = r_pad_bytes;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FIELD_BITS: n_field_bits = i_cfg_data;
                CFG_PAD_BYTES:  n_pad_bytes  = i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_bits <= FIELD_RST;
            r_pad_bytes  <= PAD_RST;
            r_acc        <= 32'd0;
            r_held       <= 5'd0;
        end else begin
            r_field_bits <= n_field_bits;
            r_pad_bytes  <= n_pad_bytes;
            if (i_accept) begin
                r_acc  <= n_acc;
                r_held <= n_held;
            end
        end
    end

endmodule

// ===== sv/bfe_queue.sv =====
// Short field queue between front and back.
module bfe_queue import bfe_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_field_ent i_ent,
    input  logic       i_pop,
    output t_field_ent o_head,
    output logic       o_full,
    output logic       o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_field_ent     r_mem [DEPTH];
    logic [AW-1:0]  r_wp, r_rp;
    logic [CW-1:0]  r_cnt;

    assign o_head  = r_mem[r_rp];
    assign o_full  = r_cnt == CW'(DEPTH);
    assign o_empty = r_cnt == '0;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full field queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty field queue");

endmodule

// ===== sv/bfe_back.sv =====
// Back end: serializes one queued field into pad and field bytes.
module bfe_back import bfe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_field_ent i_head,
    input  logic       i_empty,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run
);

    logic [2:0]  r_pos, n_pos;
    logic        r_valid;
    logic [7:0]  r_byte;
    logic        r_last;

    logic        load;
    logic        is_pad;
    logic        is_last;
    logic [2:0]  k;
    logic [1:0]  bidx;
    logic [31:0] field32;
    logic [7:0]  byte_val;

    always_comb begin
        load     = !r_valid || !i_out_stall;
        is_pad   = r_pos < {1'b0, i_head.pad};
        is_last  = r_pos == ({1'b0, i_head.pad} + {1'b0, i_head.nb_m1});
        k        = r_pos - {1'b0, i_head.pad};
        bidx     = i_head.nb_m1 - k[1:0];
        field32  = {7'd0, i_head.field};
        byte_val = is_pad ? 8'd0 : field32[{bidx, 3'b000} +: 8];
        o_pop    = load && !i_empty && is_last;
        n_pos    = r_pos;
        if (load && !i_empty) begin
            n_pos = is_last ? 3'd0 : r_pos + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= byte_val;
            r_last <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= 3'd0;
        end else begin
            r_pos <= n_pos;
            if (load) begin
                r_valid <= !i_empty;
            end
        end
    end

    assign o_out_valid   = r_valid;
    assign o_out_byte    = r_byte;
    assign o_last_of_run = r_last;

    a_mid_run_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos != 3'd0) |-> !i_empty)
        else $error("run in progress without queued field");

endmodule

// ===== sv/bit_field_expander.sv =====
// Bit field expander top level: front end, field queue and byte serializer.
// Packed stream bytes are accepted one per cycle while the field queue has
// room; each byte that completes a field queues it. The output register
// delivers one byte per cycle unless the output is stalled, and each field
// expands to pad_bytes + ceil(field_bits/8) output bytes (1 to 7). Sustained
// input rate is therefore set by the output serializer, with QUEUE_DEPTH
// fields absorbing bursts. A completing input byte is first written into the
// field queue, and its first output byte is loaded from the queue head into
// the output register.
module bit_field_expander import bfe_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [4:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_start_of_array,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run
);

    t_field_ent push_ent;
    t_field_ent head_ent;
    logic       push;
    logic       pop;
    logic       full;
    logic       empty;
    logic       accept;

    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    bfe_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_accept         (accept),
        .i_in_byte        (i_in_byte),
        .i_start_of_array (i_start_of_array),
        .o_push           (push),
        .o_ent            (push_ent)
    );

    bfe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ent   (push_ent),
        .i_pop   (pop),
        .o_head  (head_ent),
        .o_full  (full),
        .o_empty (empty)
    );

    bfe_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head_ent),
        .i_empty       (empty),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run)
    );

endmodule

// ===== tb/bfe_checker.sv =====
// Bit field expander checker: predicts every output beat and compares it with the block.
module bfe_checker import bfe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [4:0] i_cfg_data,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_start_of_array,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_out_byte,
    input  logic       i_last_of_run,
    output int         o_errors,
    output int         o_pending
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_out_beat;

    t_out_beat   expected_beats[$];
    t_out_beat   want;
    logic [4:0]  field_bits;
    logic [1:0]  pad_bytes;
    logic [31:0] stream_bits;
    logic [4:0]  held_bits;
    int          mismatches = 0;

    assign o_errors = mismatches;

    task automatic report(input string msg);
        if (mismatches < 20) $display("checker: %s", msg);
        mismatches++;
    endtask

    // Shift one stream byte in and queue the padded field it completes, if any.
    task automatic expand_byte(input logic [7:0] data, input logic soa);
        logic [4:0]  width;
        logic [31:0] mask;
        logic [5:0]  count;
        int          total;
        int          sh;
        t_out_beat   beat;
        width = (field_bits < FIELD_MIN) ? FIELD_MIN :
                (field_bits > FIELD_MAX) ? FIELD_MAX : field_bits;
        mask = (32'd1 << width) - 32'd1;
        if (soa) begin
            stream_bits = '0;
            held_bits = '0;
        end
        stream_bits = {stream_bits[23:0], data};
        count = {1'b0, held_bits} + 6'd8;
        if (count < {1'b0, width}) begin
            held_bits = count[4:0];
            return;
        end
        count = count - {1'b0, width};
        held_bits = count[4:0];
        total = (int'(width) + 7) / 8 + int'(pad_bytes);
        for (int x = 0; x < total; x++) begin
            sh = 8 * (total - x - 1);
            if (x < int'(pad_bytes))
                beat.data = 8'h00;
            else
                beat.data = 8'((stream_bits >> (int'(count) + sh)) & (mask >> sh));
            beat.last = (x == total - 1);
            expected_beats.push_back(beat);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            field_bits = FIELD_RST;
            pad_bytes = PAD_RST;
            stream_bits = '0;
            held_bits = '0;
            expected_beats.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_FIELD_BITS)
                    field_bits = i_cfg_data;
                else
                    pad_bytes = i_cfg_data[1:0];
            end
            if (i_in_valid && !i_in_stall)
                expand_byte(i_in_byte, i_start_of_array);
            if ($isunknown(i_out_valid) || $isunknown(i_in_stall))
                report("handshake signal unknown");
            if (i_out_valid && !i_out_stall) begin
                if (expected_beats.size() == 0) begin
                    report($sformatf("unexpected beat byte %h last %b", i_out_byte,
                                     i_last_of_run));
                end else begin
                    want = expected_beats.pop_front();
                    if (i_out_byte !== want.data)
                        report($sformatf("out_byte %h, expected %h", i_out_byte, want.data));
                    if (i_last_of_run !== want.last)
                        report($sformatf("last_of_run %b, expected %b", i_last_of_run,
                                         want.last));
                end
            end
        end
        o_pending <= expected_beats.size();
    end

endmodule

// ===== tb/testbench.sv =====
// Bit field expander testbench top: stimulus, stalls, configuration and verdict.
module testbench import bfe_pkg::*; ();

    localparam int LIMIT = 600000;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_idx;
    logic [4:0] cfg_data;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       start_of_array;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       last_of_run;
    int         errors;
    int         pending;
    int         cycles = 0;
    int         bytes_sent = 0;
    bit         steady = 1'b0;

    bit_field_expander i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_in_byte       (in_byte),
        .i_start_of_array(start_of_array),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_out_byte      (out_byte),
        .o_last_of_run   (last_of_run)
    );

    bfe_checker i_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_in_byte       (in_byte),
        .i_start_of_array(start_of_array),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_out_byte      (out_byte),
        .i_last_of_run   (last_of_run),
        .o_errors        (errors),
        .o_pending       (pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    initial begin : out_side
        int hold;
        int flow;
        out_stall = 1'b0;
        forever begin
            hold = steady ? 0 : pick_gap();
            flow = $urandom_range(1, 12);
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat (flow) @(posedge clk);
        end
    end

    task automatic send_byte(input logic [7:0] data, input logic soa);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= data;
        start_of_array <= soa;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        bytes_sent++;
    endtask

    // Waits until every predicted beat has come out and the block has gone quiet.
    task automatic drain();
        int quiet;
        quiet = 0;
        in_valid <= 1'b0;
        while (quiet < 8) begin
            @(posedge clk);
            quiet = (pending == 0) ? quiet + 1 : 0;
        end
    endtask

    task automatic set_config(input logic [4:0] width, input logic [4:0] pad_word);
        cfg_we <= 1'b1;
        cfg_idx <= CFG_FIELD_BITS;
        cfg_data <= width;
        @(posedge clk);
        cfg_idx <= CFG_PAD_BYTES;
        cfg_data <= pad_word;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_array(input int len);
        int         mode;
        logic [7:0] data;
        mode = $urandom_range(0, 9);
        for (int k = 0; k < len; k++) begin
            case (mode)
                0: data = 8'hFF;
                1: data = 8'h00;
                default: data = 8'($urandom);
            endcase
            send_byte(data, k == 0 || $urandom_range(0, 49) == 0);
        end
    endtask

    initial begin : stimulus
        logic [4:0] width;
        int         phase;
        int         target;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = CFG_FIELD_BITS;
        cfg_data = '0;
        in_valid = 1'b0;
        in_byte = '0;
        start_of_array = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset widths: 21-bit fields, no pad
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        drain();
        // width below range clamps to 8, full pad
        set_config(5'd0, 5'd3);
        send_byte(8'h80, 1'b1);
        send_byte(8'h01, 1'b0);
        drain();
        // width above range clamps to 25; start flag mid-stream drops held bits
        set_config(5'd31, 5'd0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b1);
        drain();
        // longest run: 25-bit field behind three pad bytes
        set_config(5'd25, 5'd3);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        drain();
        set_config(5'd8, 5'd0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        drain();

        phase = 0;
        target = bytes_sent + 375;
        while (bytes_sent < target) begin
            case (phase)
                0: width = 5'd8;
                1: width = 5'd25;
                2: width = 5'd0;
                3: width = 5'd31;
                4: width = 5'd16;
                5: width = 5'd17;
                default: width = ($urandom_range(0, 9) == 0) ? 5'($urandom)
                                                            : 5'($urandom_range(8, 25));
            endcase
            steady = (phase % 5 == 3);
            set_config(width, {3'($urandom), 2'(phase < 4 ? phase : $urandom)});
            repeat ($urandom_range(2, 5)) send_array($urandom_range(1, 16));
            drain();
            phase++;
        end

        steady = 1'b0;
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
